### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Types and constants of the two-wire byte shifter.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd600;
    localparam logic [15:0] PHASE_TICKS_MIN   = 16'd1;

    // Bit counter marks: data bits end at 8, receive ack bit ends at 9.
    localparam logic [3:0] BIT_IDX_ACK  = 4'd8;
    localparam logic [3:0] BIT_IDX_DONE = 4'd9;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } tws_op_t;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } tws_phase_t;

    typedef struct packed {
        logic       busy;
        tws_op_t    op_mode;
        logic [3:0] bit_index;
        tws_phase_t phase_step;
        logic [15:0] tick_count;
        logic [7:0] shift_byte;
        logic       scl;
        logic       sda;
        logic       sda_dir;
        logic       ack_hold;
    } tws_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } tws_result_t;

    // Drive the pins for the phase now in s.phase_step and restart its tick count.
    function automatic tws_state_t tws_apply_phase(input tws_state_t s);
        tws_state_t r;
        r = s;
        case (s.phase_step)
            PH_SETUP: begin
                r.scl = 1'b0;
                if (s.op_mode == OP_SEND) begin
                    r.sda_dir = 1'b1;
                    r.sda     = s.shift_byte[7];
                end else if (s.bit_index < BIT_IDX_ACK) begin
                    r.sda_dir = 1'b0;
                end else begin
                    r.sda_dir = 1'b1;
                    r.sda     = s.ack_hold;
                end
            end
            PH_HIGH: r.scl = 1'b1;
            default: r.scl = 1'b0;
        endcase
        r.tick_count = 16'd1;
        return r;
    endfunction

endpackage

### rtl/two_wire_byte_shifter.sv
// ----------------------------------------------------------------------------
// two_wire_byte_shifter
// Two-wire master byte engine advanced by one input transaction per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ transaction is one tick: a start request with its operation type,
//   byte to send and ack level, plus the sampled SDA line. Each tick yields
//   exactly one m_ transaction with the SCL/SDA pin levels, SDA direction,
//   busy, a one-tick done flag and the received byte (nonzero only on done
//   of a receive).
//   A send clocks 8 bits out MSB first, three phases per bit (setup, SCL high,
//   SCL low), each phase lasting phase_ticks ticks. A receive releases SDA,
//   samples 8 bits at the end of each SCL-high phase, then drives the ack bit.
//   cfg_phase_ticks is written through cfg_valid/cfg_ready; cfg_ready is
//   always high. A write applies from the next tick, even mid-byte. Zero acts as one.
//   The result of a tick is registered, in the output or the skid register.
//   Throughput: one tick per cycle while s_ready is high; the state update is a
//   single pass of logic between the state registers and the result register.
//   Stall: when m_ready is low a skid register takes one more transaction,
//   then s_ready drops until the output drains.
//   Reset (aresetn low, synchronous): engine idle, SCL low, SDA driven low,
//   phase_ticks back to 600, result buffer empty.
// ----------------------------------------------------------------------------
module two_wire_byte_shifter import tws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_phase_ticks,
    // tick input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic        s_req_type,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_ack_level,
    input  logic        s_sda_in,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic        m_sda_drive,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rx_byte
);

    tws_result_t step_result;
    tws_result_t out_result;
    logic        tick_en;

    // Configuration never stalls.
    assign cfg_ready = 1'b1;

    // Advance the engine only on an accepted tick transaction.
    assign tick_en = s_valid && s_ready;

    tws_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_phase_ticks),
        .tick_en   (tick_en),
        .start_req (s_start_req),
        .req_type  (s_req_type),
        .tx_byte   (s_tx_byte),
        .ack_level (s_ack_level),
        .sda_in    (s_sda_in),
        .result    (step_result)
    );

    // Hold results here while the receiver stalls.
    tws_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (step_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_scl_level = out_result.scl_level;
    assign m_sda_level = out_result.sda_level;
    assign m_sda_drive = out_result.sda_drive;
    assign m_busy_res  = out_result.busy_res;
    assign m_done_res  = out_result.done_res;
    assign m_rx_byte   = out_result.rx_byte;

endmodule

### rtl/tws_engine.sv
// ----------------------------------------------------------------------------
// tws_engine
// Per-tick state update of the byte engine and the phase length register.
// ----------------------------------------------------------------------------
module tws_engine import tws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        tick_en,
    input  logic        start_req,
    input  logic        req_type,
    input  logic [7:0]  tx_byte,
    input  logic        ack_level,
    input  logic        sda_in,
    output tws_result_t result
);

    tws_state_t  state_reg;
    tws_state_t  state_next;
    logic [15:0] phase_ticks_reg;
    logic [15:0] limit;
    logic        done;

    assign limit = (phase_ticks_reg == '0) ? PHASE_TICKS_MIN : phase_ticks_reg;

    always_comb begin
        tws_state_t s;
        s    = state_reg;
        done = 1'b0;
        if (state_reg.busy) begin
            if (state_reg.tick_count >= limit) begin
                case (state_reg.phase_step)
                    PH_SETUP: begin
                        s.phase_step = PH_HIGH;
                        s = tws_apply_phase(s);
                    end
                    PH_HIGH: begin
                        if (s.op_mode == OP_RECV && s.bit_index < BIT_IDX_ACK) begin
                            s.shift_byte = {s.shift_byte[6:0], sda_in};
                        end
                        s.phase_step = PH_LOW;
                        s = tws_apply_phase(s);
                    end
                    default: begin
                        s.bit_index = s.bit_index + 4'd1;
                        if (s.op_mode == OP_SEND) begin
                            s.shift_byte = {s.shift_byte[6:0], 1'b0};
                            done = (s.bit_index >= BIT_IDX_ACK);
                            s.phase_step = PH_SETUP;
                        end else begin
                            done = (s.bit_index >= BIT_IDX_DONE);
                            s.phase_step = (s.bit_index == BIT_IDX_ACK) ? PH_SETUP : PH_HIGH;
                        end
                        if (done) begin
                            s.busy       = 1'b0;
                            s.scl        = 1'b0;
                            s.bit_index  = '0;
                            s.phase_step = PH_SETUP;
                            s.tick_count = '0;
                        end else begin
                            s = tws_apply_phase(s);
                        end
                    end
                endcase
            end else begin
                s.tick_count = state_reg.tick_count + 16'd1;
            end
        end else if (start_req) begin
            s.busy       = 1'b1;
            s.op_mode    = tws_op_t'(req_type);
            s.ack_hold   = ack_level;
            s.shift_byte = req_type ? 8'd0 : tx_byte;
            s.bit_index  = '0;
            s.phase_step = PH_SETUP;
            s = tws_apply_phase(s);
        end
        state_next = s;
    end

    always_comb begin
        result.scl_level = state_next.scl;
        result.sda_level = state_next.sda_dir & state_next.sda;
        result.sda_drive = state_next.sda_dir;
        result.busy_res  = state_next.busy;
        result.done_res  = done;
        result.rx_byte   = (done && state_next.op_mode == OP_RECV) ?
                           state_next.shift_byte : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{busy: 1'b0, op_mode: OP_SEND, bit_index: 4'd0,
                           phase_step: PH_SETUP, tick_count: 16'd0, shift_byte: 8'd0,
                           scl: 1'b0, sda: 1'b0, sda_dir: 1'b1, ack_hold: 1'b0};
        end else if (tick_en) begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/tws_skid.sv
// ----------------------------------------------------------------------------
// tws_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module tws_skid import tws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  tws_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tws_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    tws_result_t out_data_reg;
    tws_result_t skid_data_reg;
    logic        load;
    logic        out_free;

    assign in_ready  = !skid_valid_reg;
    assign load      = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= load;
            end
        end else if (load) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (load) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

### rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the two-wire byte shifter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_sda_level,
    input logic       m_sda_drive,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_rx_byte
);

    // A finished operation is no longer busy.
    `ASSERT_IMPL(a_done_not_busy, aclk, aresetn, m_valid && m_done_res, !m_busy_res, "done while busy")

    // Received byte shows only on a done transaction.
    `ASSERT_IMPL(a_rx_only_on_done, aclk, aresetn, m_valid && !m_done_res, m_rx_byte == 8'd0, "rx byte without done")

    // A released SDA reads as level zero.
    `ASSERT_IMPL(a_released_low, aclk, aresetn, m_valid && !m_sda_drive, !m_sda_level, "SDA level while released")

    // Stalled result holds.
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rx_byte) && $stable(m_done_res), "stalled result changed")

    // Buffer is empty out of reset, so input is ready.
    `ASSERT_IMPL(a_ready_after_reset, aclk, aresetn, !$past(aresetn), s_ready, "not ready after reset")

endmodule

bind two_wire_byte_shifter tws_checker u_tws_checker (.*);

### bench/tb_two_wire_byte_shifter.sv
// ----------------------------------------------------------------------------
// tb_two_wire_byte_shifter
// Self-checking bench for the two-wire master byte engine. Every accepted
// input transaction is one engine tick. A local model of the engine predicts
// the pin levels, busy, done and received byte for that tick. Results are
// compared field by field, in order, against those predictions. A short
// directed table runs first, then random ticks under several phase lengths,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_two_wire_byte_shifter import tws_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limit, far above the slowest correct run.
    localparam int RUN_LIMIT      = 200_000;
    localparam int SETTLE_CYCLES  = 4;     // idle wait after the last result
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TICKS_PER_SET  = 160;
    localparam int REPORT_LIMIT   = 10;

    typedef enum {ROW_TICK, ROW_DRAIN, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        start;
        logic        rtype;
        logic [7:0]  tx;
        logic        ack;
        logic        sda;
        logic        typed;
        tws_result_t want;
        logic [15:0] len;
    } stim_row_t;

    // Expected pin states that can be read straight off the spec.
    localparam tws_result_t RES_NONE = '0;
    localparam tws_result_t RES_IDLE = '{scl_level: 1'b0, sda_level: 1'b0,
        sda_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0, rx_byte: 8'h00};
    localparam tws_result_t RES_SEND_ONE = '{scl_level: 1'b0, sda_level: 1'b1,
        sda_drive: 1'b1, busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00};
    localparam tws_result_t RES_SEND_ZERO = '{scl_level: 1'b0, sda_level: 1'b0,
        sda_drive: 1'b1, busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00};
    localparam tws_result_t RES_RECV_OPEN = '{scl_level: 1'b0, sda_level: 1'b0,
        sda_drive: 1'b0, busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00};

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_phase_ticks = 16'd0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_start_req     = 1'b0;
    logic        s_req_type      = 1'b0;
    logic [7:0]  s_tx_byte       = 8'h00;
    logic        s_ack_level     = 1'b0;
    logic        s_sda_in        = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_scl_level;
    logic        m_sda_level;
    logic        m_sda_drive;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_rx_byte;

    // Engine model state, advanced once per accepted tick.
    logic        eng_busy;
    tws_op_t     eng_op;
    logic [3:0]  eng_bit;
    tws_phase_t  eng_phase;
    logic [15:0] eng_ticks;
    logic [7:0]  eng_shift;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_dir;
    logic        eng_ack;
    logic [15:0] eng_phase_len;

    tws_result_t pin_expect_q[$];
    stim_row_t   directed_tbl[$];
    int          err_cnt      = 0;
    int          burst_left   = 0;
    int unsigned cycle_cnt    = 0;
    logic        holdoff_req  = 1'b0;
    logic        holding      = 1'b0;

    two_wire_byte_shifter u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_phase_ticks (cfg_phase_ticks),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_req_type      (s_req_type),
        .s_tx_byte       (s_tx_byte),
        .s_ack_level     (s_ack_level),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_level     (m_scl_level),
        .m_sda_level     (m_sda_level),
        .m_sda_drive     (m_sda_drive),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_rx_byte       (m_rx_byte)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Engine model
    // ------------------------------------------------------------------

    // Drive the pins for the phase just entered and restart its count.
    // SCL is high only in the high phase. SDA changes only in a setup
    // phase: data bit on a send, released for receive data, ack level
    // for the ack bit.
    function automatic void load_phase();
        eng_scl = (eng_phase == PH_HIGH);
        if (eng_phase == PH_SETUP) begin
            if (eng_op == OP_SEND) begin
                eng_dir = 1'b1;
                eng_sda = eng_shift[7];
            end else if (eng_bit < BIT_IDX_ACK) begin
                eng_dir = 1'b0;
            end else begin
                eng_dir = 1'b1;
                eng_sda = eng_ack;
            end
        end
        eng_ticks = 16'd1;
    endfunction

    // Step to the next phase. Return 1 when the byte has finished.
    function automatic logic advance_phase(input logic sda_bit);
        logic fin;
        fin = 1'b0;
        case (eng_phase)
            PH_SETUP: eng_phase = PH_HIGH;
            PH_HIGH: begin
                // Sample the line as the high phase closes (data bits only).
                if (eng_op == OP_RECV && eng_bit < BIT_IDX_ACK)
                    eng_shift = {eng_shift[6:0], sda_bit};
                eng_phase = PH_LOW;
            end
            default: begin
                eng_bit = eng_bit + 4'd1;
                if (eng_op == OP_SEND) begin
                    eng_shift = eng_shift << 1;
                    fin       = (eng_bit >= BIT_IDX_ACK);
                    eng_phase = PH_SETUP;
                end else begin
                    // Receive bits 1..7 skip setup; the ack bit has one.
                    fin       = (eng_bit >= BIT_IDX_DONE);
                    eng_phase = (eng_bit == BIT_IDX_ACK) ? PH_SETUP : PH_HIGH;
                end
            end
        endcase
        if (!fin)
            load_phase();
        return fin;
    endfunction

    function automatic tws_result_t predict_tick(input logic start, input logic rtype,
                                                 input logic [7:0] tx, input logic ack,
                                                 input logic sda_bit);
        tws_result_t r;
        logic        fin;
        logic [15:0] span;
        fin  = 1'b0;
        span = (eng_phase_len == 16'd0) ? 16'd1 : eng_phase_len;
        if (eng_busy) begin
            // A start request while busy is dropped.
            if (eng_ticks >= span) begin
                fin = advance_phase(sda_bit);
                if (fin) begin
                    eng_busy  = 1'b0;
                    eng_scl   = 1'b0;
                    eng_bit   = 4'd0;
                    eng_phase = PH_SETUP;
                    eng_ticks = 16'd0;
                end
            end else begin
                eng_ticks = eng_ticks + 16'd1;
            end
        end else if (start) begin
            eng_busy  = 1'b1;
            eng_op    = tws_op_t'(rtype);
            eng_ack   = ack;
            eng_shift = (eng_op == OP_SEND) ? tx : 8'h00;
            eng_bit   = 4'd0;
            eng_phase = PH_SETUP;
            load_phase();
        end
        r.scl_level = eng_scl;
        r.sda_level = eng_dir & eng_sda;
        r.sda_drive = eng_dir;
        r.busy_res  = eng_busy;
        r.done_res  = fin;
        r.rx_byte   = (fin && eng_op == OP_RECV) ? eng_shift : 8'h00;
        return r;
    endfunction

    function automatic stim_row_t stim_row(input row_kind_t kind, input logic start,
                                           input logic rtype, input logic [7:0] tx,
                                           input logic ack, input logic sda,
                                           input logic typed, input tws_result_t want,
                                           input logic [15:0] len);
        stim_row_t r;
        r.kind  = kind;
        r.start = start;
        r.rtype = rtype;
        r.tx    = tx;
        r.ack   = ack;
        r.sda   = sda;
        r.typed = typed;
        r.want  = want;
        r.len   = len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one tick, hold it until accepted, then log its expected result.
    // End each burst with a gap so valid never drops and rises in one step.
    task automatic offer_tick(input logic start, input logic rtype, input logic [7:0] tx,
                              input logic ack, input logic sda,
                              input logic typed, input tws_result_t want);
        tws_result_t model_res;
        if (!s_valid)
            s_valid <= 1'b1;
        s_start_req <= start;
        s_req_type  <= rtype;
        s_tx_byte   <= tx;
        s_ack_level <= ack;
        s_sda_in    <= sda;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        model_res = predict_tick(start, rtype, tx, ack, sda);
        pin_expect_q.push_back(typed ? want : model_res);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge aclk);
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
    endtask

    // Drop valid and hold until every expected result has arrived.
    task automatic pause_sender();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (pin_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    // Feed plain ticks until the model says the engine is idle again.
    task automatic run_to_idle(input logic fixed_sda, input logic sda);
        while (eng_busy)
            offer_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)),
                       fixed_sda ? sda : 1'($urandom_range(0, 1)),
                       1'b0, RES_NONE);
    endtask

    // Write the phase length once every result is in; the engine may be
    // mid-byte, the new length applies from the next tick.
    task automatic write_phase_len(input logic [15:0] len);
        pause_sender();
        cfg_valid       <= 1'b1;
        cfg_phase_ticks <= len;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid     <= 1'b0;
        eng_phase_len  = len;
    endtask

    task automatic random_ticks(input int n);
        repeat (n)
            offer_tick($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'b0, RES_NONE);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Advance the cycle count and end the run if it never settles.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Long receiver hold-off, requested once by the stimulus. The sender
    // keeps offering meanwhile, so the skid buffer fills and s_ready drops.
    initial begin
        do
            @(posedge aclk);
        while (!holdoff_req);
        holding <= 1'b1;
        repeat (HOLDOFF_CYCLES)
            @(posedge aclk);
        holding <= 1'b0;
    end

    // Check each result transaction against the oldest expectation, then
    // pick the next ready level. The stall pattern rotates with cycle count
    // bits 7:6: always ready, mostly ready, a fixed 3-of-4 pattern, coin flip.
    always @(posedge aclk) begin
        tws_result_t got;
        tws_result_t want;
        logic        rdy;
        if (aresetn && m_valid && m_ready) begin
            got = '{scl_level: m_scl_level, sda_level: m_sda_level,
                    sda_drive: m_sda_drive, busy_res: m_busy_res,
                    done_res: m_done_res, rx_byte: m_rx_byte};
            if (pin_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_LIMIT)
                    $display("cycle %0d: result with nothing expected: %p", cycle_cnt, got);
            end else begin
                want = pin_expect_q.pop_front();
                if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                    got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res || got.rx_byte !== want.rx_byte) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display({"cycle %0d: mismatch (exp/got) scl %b/%b sda %b/%b ",
                                  "drive %b/%b busy %b/%b done %b/%b rx %02h/%02h"},
                                 cycle_cnt, want.scl_level, got.scl_level,
                                 want.sda_level, got.sda_level, want.sda_drive,
                                 got.sda_drive, want.busy_res, got.busy_res,
                                 want.done_res, got.done_res, want.rx_byte, got.rx_byte);
                end
            end
        end
        case (cycle_cnt[7:6])
            2'd0:    rdy = 1'b1;
            2'd1:    rdy = ($urandom_range(0, 3) != 0);
            2'd2:    rdy = (cycle_cnt[1:0] != 2'd0);
            default: rdy = 1'($urandom_range(0, 1));
        endcase
        m_ready <= rdy && !holding;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] set_lens[$];

        // Model state after reset.
        eng_busy      = 1'b0;
        eng_op        = OP_SEND;
        eng_bit       = 4'd0;
        eng_phase     = PH_SETUP;
        eng_ticks     = 16'd0;
        eng_shift     = 8'h00;
        eng_scl       = 1'b0;
        eng_sda       = 1'b0;
        eng_dir       = 1'b1;
        eng_ack       = 1'b0;
        eng_phase_len = PHASE_TICKS_RESET;
        burst_left    = $urandom_range(1, 40);

        // Directed part: reset phase length first, then the shortest ones.
        // Typed rows carry expectations visible at a glance; the rest use
        // the model.
        directed_tbl.push_back(stim_row(ROW_TICK, 0, 0, 8'h00, 0, 0, 1, RES_IDLE, 0));
        // Request fields without start: ignore them.
        directed_tbl.push_back(stim_row(ROW_TICK, 0, 1, 8'hFF, 1, 1, 1, RES_IDLE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 0, 8'h80, 0, 0, 1, RES_SEND_ONE, 0));
        // Start while busy: drop it, first phase keeps counting.
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 1, 8'h00, 1, 1, 1, RES_SEND_ONE, 0));
        // Shorten the phase mid-byte, then let the send finish.
        directed_tbl.push_back(stim_row(ROW_CFG, 0, 0, 8'h00, 0, 0, 0, RES_NONE,
                                        PHASE_TICKS_MIN));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 0, 8'h00, 1, 1, 1, RES_SEND_ZERO, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 1, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 0, 8'hFF, 0, 0, 1, RES_SEND_ONE, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 0));
        // Receive all ones with ack low, then all zeros with ack high.
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 1, 8'hFF, 0, 1, 1, RES_RECV_OPEN, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 1, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 1, 8'h00, 1, 0, 1, RES_RECV_OPEN, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 0));
        // Zero phase length behaves as one.
        directed_tbl.push_back(stim_row(ROW_CFG, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 16'd0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 0, 8'hA5, 0, 0, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 1, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 1, 8'h5A, 1, 1, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 1, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_CFG, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 16'd2));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 0, 8'h5A, 1, 0, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 0, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_TICK, 1, 1, 8'hC3, 0, 0, 0, RES_NONE, 0));
        directed_tbl.push_back(stim_row(ROW_DRAIN, 0, 0, 8'h00, 0, 1, 0, RES_NONE, 0));

        // Hold reset, then release it once.
        repeat (10)
            @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tbl[i]) begin
            case (directed_tbl[i].kind)
                ROW_TICK:  offer_tick(directed_tbl[i].start, directed_tbl[i].rtype,
                                      directed_tbl[i].tx, directed_tbl[i].ack,
                                      directed_tbl[i].sda, directed_tbl[i].typed,
                                      directed_tbl[i].want);
                ROW_DRAIN: run_to_idle(1'b1, directed_tbl[i].sda);
                default:   write_phase_len(directed_tbl[i].len);
            endcase
        end

        // Random ticks under a spread of phase lengths, including zero.
        // Settle the engine and drain all results before each write.
        set_lens = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd1,
                     16'($urandom_range(1, 6)), 16'd5};
        foreach (set_lens[k]) begin
            write_phase_len(set_lens[k]);
            if (k == 4)
                holdoff_req <= 1'b1;
            random_ticks(TICKS_PER_SET);
            run_to_idle(1'b0, 1'b0);
        end

        // Longest phase: start one send and hold it in its first phase,
        // then shorten the phase and let the send finish.
        write_phase_len(16'hFFFF);
        offer_tick(1'b1, OP_SEND, 8'hC3, 1'b0, 1'b0, 1'b0, RES_NONE);
        random_ticks(20);
        write_phase_len(PHASE_TICKS_MIN);
        run_to_idle(1'b0, 1'b0);

        pause_sender();
        if (err_cnt == 0 && pin_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### two_wire_byte_shifter.f
+incdir+rtl
rtl/tws_pkg.sv
rtl/tws_engine.sv
rtl/tws_skid.sv
rtl/two_wire_byte_shifter.sv
rtl/tws_checker.sv
bench/tb_two_wire_byte_shifter.sv
